/* hdl/kcdd_pkg.sv */
package kcdd_pkg;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_AUTO    = 2'd2
  } mode_t;

  localparam logic [7:0] KEY_UPPER_A = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [7:0] KEY_C     = 8'h63;
  localparam logic [7:0] KEY_M     = 8'h6D;
  localparam logic [7:0] KEY_O     = 8'h6F;
  localparam logic [7:0] KEY_W     = 8'h77;
  localparam logic [7:0] KEY_S     = 8'h73;
  localparam logic [7:0] KEY_A     = 8'h61;
  localparam logic [7:0] KEY_D     = 8'h64;
  localparam logic [7:0] KEY_B     = 8'h62;
  localparam logic [7:0] KEY_N     = 8'h6E;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_J     = 8'h6A;
  localparam logic [7:0] KEY_U     = 8'h75;
  localparam logic [7:0] KEY_P     = 8'h70;

  localparam logic signed [7:0] SPEED_STEP  = 8'sd5;
  localparam logic signed [7:0] SPEED_BOUND = 8'sd100;
  localparam logic signed [7:0] SPEED_FLOOR = -8'sd100;

  localparam logic [7:0] ANGLE_STEP       = 8'd5;
  localparam logic [7:0] ANGLE_UPPER_GATE = 8'd176;
  localparam logic [7:0] ANGLE_LOWER_GATE = 8'd4;

  localparam logic [10:0] PULSE_SPAN   = 11'd1800;
  localparam logic [7:0]  PULSE_BASE   = 8'd50;
  // ceil(2^16 / 9); exact floor for numerators up to 1800
  localparam logic [12:0] RECIP_NINE   = 13'd7282;

  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic [5:0]        right_fwd_duty;
    logic [5:0]        right_rev_duty;
    logic [5:0]        left_fwd_duty;
    logic [5:0]        left_rev_duty;
    logic [7:0]        servo_pulse;
    logic [7:0]        steer_angle;
    mode_t             mode;
    logic              paused;
  } result_t;

  function automatic logic [7:0] servo_pulse_of(input logic [7:0] angle);
    logic [10:0] ang_x10;
    logic [10:0] num;
    logic [23:0] prod;
    ang_x10 = {angle, 3'b000} + {2'b00, angle, 1'b0};
    num     = PULSE_SPAN - ang_x10;
    prod    = {13'd0, num} * {11'd0, RECIP_NINE};
    return PULSE_BASE + prod[23:16];
  endfunction

endpackage

/* hdl/key_command_differential_drive_core.sv */
// Pipeline: an accepted key transaction passes the input register, then the result
//   register. Throughput: one key per cycle unless result_ready stalls the output;
//   the speed/angle state update is a single pass.
// Reset (rst, synchronous): speeds, angle, pause flag cleared, mode standby,
//   both pipeline stages emptied. Saved speeds are not reset.
module key_command_differential_drive_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        key_code,
  input  logic              key_valid,
  output logic              key_ready,
  output logic signed [7:0] left_speed,
  output logic signed [7:0] right_speed,
  output logic [5:0]        right_fwd_duty,
  output logic [5:0]        right_rev_duty,
  output logic [5:0]        left_fwd_duty,
  output logic [5:0]        left_rev_duty,
  output logic [7:0]        servo_pulse,
  output logic [7:0]        steer_angle_out,
  output logic [1:0]        mode_out,
  output logic              paused_out,
  output logic              result_valid,
  input  logic              result_ready
);
  import kcdd_pkg::*;

  logic       advance;
  logic       stage_valid;
  logic [7:0] stage_key;
  logic       fire;
  result_t    res_next;
  result_t    res_q;

  assign fire = stage_valid && advance;

  kcdd_input_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .key_code    (key_code),
    .key_valid   (key_valid),
    .key_ready   (key_ready),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_key   (stage_key)
  );

  kcdd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .key      (stage_key),
    .res_next (res_next)
  );

  kcdd_output_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .res_in       (res_next),
    .advance      (advance),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .res_out      (res_q)
  );

  assign left_speed      = res_q.left_speed;
  assign right_speed     = res_q.right_speed;
  assign right_fwd_duty  = res_q.right_fwd_duty;
  assign right_rev_duty  = res_q.right_rev_duty;
  assign left_fwd_duty   = res_q.left_fwd_duty;
  assign left_rev_duty   = res_q.left_rev_duty;
  assign servo_pulse     = res_q.servo_pulse;
  assign steer_angle_out = res_q.steer_angle;
  assign mode_out        = res_q.mode;
  assign paused_out      = res_q.paused;

endmodule

/* hdl/kcdd_input_stage.sv */
module kcdd_input_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] key_code,
  input  logic       key_valid,
  output logic       key_ready,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_key
);
  import kcdd_pkg::*;

  assign key_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (key_ready) begin
      stage_valid <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_ready && key_valid) begin
      stage_key <= key_code;
    end
  end

endmodule

/* hdl/kcdd_core.sv */
module kcdd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        key,
  output kcdd_pkg::result_t res_next
);
  import kcdd_pkg::*;

  logic signed [7:0] left_speed_reg, left_speed_next;
  logic signed [7:0] right_speed_reg, right_speed_next;
  logic signed [7:0] saved_left, saved_left_next;
  logic signed [7:0] saved_right, saved_right_next;
  logic              paused_flag, paused_flag_next;
  logic [7:0]        steer_angle, steer_angle_next;
  mode_t             control_mode, control_mode_next;

  logic [7:0] key_fold;
  logic [8:0] speed_sum;
  logic [8:0] speed_adj;
  logic [7:0] left_neg, right_neg;

  assign key_fold = (key >= KEY_UPPER_A && key <= KEY_UPPER_Z) ? key + CASE_OFFSET : key;

  // average truncated toward zero: bias negative sums by one before the shift
  assign speed_sum = {left_speed_reg[7], left_speed_reg} + {right_speed_reg[7], right_speed_reg};
  assign speed_adj = speed_sum + {8'd0, speed_sum[8]};

  always_comb begin
    left_speed_next   = left_speed_reg;
    right_speed_next  = right_speed_reg;
    saved_left_next   = saved_left;
    saved_right_next  = saved_right;
    paused_flag_next  = paused_flag;
    steer_angle_next  = steer_angle;
    control_mode_next = control_mode;
    unique case (key_fold)
      KEY_C: control_mode_next = MODE_AUTO;
      KEY_M: control_mode_next = MODE_MANUAL;
      KEY_O: begin
        control_mode_next = MODE_STANDBY;
        left_speed_next   = '0;
        right_speed_next  = '0;
        steer_angle_next  = '0;
      end
      default: begin
        if (control_mode == MODE_MANUAL) begin
          case (key_fold)
            KEY_W: begin
              if (left_speed_reg < SPEED_BOUND && right_speed_reg < SPEED_BOUND) begin
                left_speed_next  = left_speed_reg + SPEED_STEP;
                right_speed_next = right_speed_reg + SPEED_STEP;
              end
            end
            KEY_S: begin
              if (left_speed_reg > SPEED_FLOOR && right_speed_reg > SPEED_FLOOR) begin
                left_speed_next  = left_speed_reg - SPEED_STEP;
                right_speed_next = right_speed_reg - SPEED_STEP;
              end
            end
            KEY_A: begin
              if (left_speed_reg > SPEED_FLOOR) left_speed_next = left_speed_reg - SPEED_STEP;
              if (right_speed_reg < SPEED_BOUND) right_speed_next = right_speed_reg + SPEED_STEP;
            end
            KEY_D: begin
              if (right_speed_reg > SPEED_FLOOR) right_speed_next = right_speed_reg - SPEED_STEP;
              if (left_speed_reg < SPEED_BOUND) left_speed_next = left_speed_reg + SPEED_STEP;
            end
            KEY_B: begin
              saved_left_next  = left_speed_reg;
              saved_right_next = right_speed_reg;
              left_speed_next  = '0;
              right_speed_next = '0;
              paused_flag_next = 1'b1;
            end
            KEY_N: begin
              if (paused_flag) begin
                left_speed_next  = saved_left;
                right_speed_next = saved_right;
                paused_flag_next = 1'b0;
              end
            end
            KEY_SPACE: begin
              left_speed_next  = speed_adj[8:1];
              right_speed_next = speed_adj[8:1];
            end
            KEY_J: begin
              if (steer_angle < ANGLE_UPPER_GATE) steer_angle_next = steer_angle + ANGLE_STEP;
            end
            KEY_U: begin
              if (steer_angle > ANGLE_LOWER_GATE) steer_angle_next = steer_angle - ANGLE_STEP;
            end
            KEY_P: begin
              left_speed_next  = '0;
              right_speed_next = '0;
              steer_angle_next = '0;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  assign left_neg  = 8'd0 - left_speed_next;
  assign right_neg = 8'd0 - right_speed_next;

  always_comb begin
    res_next.left_speed     = left_speed_next;
    res_next.right_speed    = right_speed_next;
    res_next.right_fwd_duty = (right_speed_next > 8'sd0) ? right_speed_next[6:1] : 6'd0;
    res_next.right_rev_duty = (right_speed_next > 8'sd0) ? 6'd0 : right_neg[6:1];
    res_next.left_fwd_duty  = (left_speed_next > 8'sd0) ? left_speed_next[6:1] : 6'd0;
    res_next.left_rev_duty  = (left_speed_next > 8'sd0) ? 6'd0 : left_neg[6:1];
    res_next.servo_pulse    = servo_pulse_of(steer_angle_next);
    res_next.steer_angle    = steer_angle_next;
    res_next.mode           = control_mode_next;
    res_next.paused         = paused_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed_reg  <= '0;
      right_speed_reg <= '0;
      paused_flag     <= 1'b0;
      steer_angle     <= '0;
      control_mode    <= MODE_STANDBY;
    end else if (fire) begin
      left_speed_reg  <= left_speed_next;
      right_speed_reg <= right_speed_next;
      paused_flag     <= paused_flag_next;
      steer_angle     <= steer_angle_next;
      control_mode    <= control_mode_next;
    end
  end

  // saved speeds are only read after b has written them
  always_ff @(posedge clk) begin
    if (fire) begin
      saved_left  <= saved_left_next;
      saved_right <= saved_right_next;
    end
  end

endmodule

/* hdl/kcdd_output_stage.sv */
module kcdd_output_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              stage_valid,
  input  kcdd_pkg::result_t res_in,
  output logic              advance,
  input  logic              result_ready,
  output logic              result_valid,
  output kcdd_pkg::result_t res_out
);
  import kcdd_pkg::*;

  assign advance = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res_out <= res_in;
    end
  end

endmodule

/* hdl/kcdd_checker.sv */
module kcdd_checker (
  input logic              clk,
  input logic              rst,
  input logic signed [7:0] left_speed,
  input logic signed [7:0] right_speed,
  input logic [5:0]        right_fwd_duty,
  input logic [5:0]        right_rev_duty,
  input logic [5:0]        left_fwd_duty,
  input logic [5:0]        left_rev_duty,
  input logic [7:0]        servo_pulse,
  input logic [7:0]        steer_angle_out,
  input logic [1:0]        mode_out,
  input logic              result_valid,
  input logic              result_ready
);
  import kcdd_pkg::*;

  // a stalled result transaction holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(left_speed)
      && $stable(right_speed) && $stable(servo_pulse) && $stable(mode_out))
    else $error("result changed while stalled");

  // standby is entered only by reset or o, both of which zero the speeds
  a_standby_still: assert property (@(posedge clk) disable iff (rst)
    result_valid && mode_out == MODE_STANDBY |-> left_speed == 8'sd0 && right_speed == 8'sd0)
    else $error("speed nonzero in standby");

  a_duty_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (left_fwd_duty == 6'd0 || left_rev_duty == 6'd0)
      && (right_fwd_duty == 6'd0 || right_rev_duty == 6'd0))
    else $error("forward and reverse duty both active");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> steer_angle_out <= 8'd180 && servo_pulse >= 8'd50 && servo_pulse <= 8'd250)
    else $error("steering angle or servo pulse out of range");

endmodule

bind key_command_differential_drive_core kcdd_checker u_kcdd_checker (.*);

/* dv/drive_state_checker.sv */
`timescale 1ns / 1ps

module drive_state_checker
  import kcdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        key_code,
  input  logic              key_valid,
  input  logic              key_ready,
  input  logic signed [7:0] left_speed,
  input  logic signed [7:0] right_speed,
  input  logic [5:0]        right_fwd_duty,
  input  logic [5:0]        right_rev_duty,
  input  logic [5:0]        left_fwd_duty,
  input  logic [5:0]        left_rev_duty,
  input  logic [7:0]        servo_pulse,
  input  logic [7:0]        steer_angle_out,
  input  logic [1:0]        mode_out,
  input  logic              paused_out,
  input  logic              result_valid,
  input  logic              result_ready,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct {
    logic [7:0] key;
    result_t    res;
  } key_result_t;

  key_result_t pending_results[$];

  // predicted drive state
  int    left_v;
  int    right_v;
  int    held_left;
  int    held_right;
  int    angle_deg;
  bit    paused_now;
  mode_t mode_now;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [5:0] fwd_duty_of(input int v);
    int half;
    half = (v > 0) ? v / 2 : 0;
    return half[5:0];
  endfunction

  function automatic logic [5:0] rev_duty_of(input int v);
    int half;
    half = (v > 0) ? 0 : (-v) / 2;
    return half[5:0];
  endfunction

  // Updates the predicted state for one key and returns the reported state.
  function automatic result_t apply_key(input logic [7:0] raw);
    logic [7:0] k;
    int         l;
    int         r;
    int         a;
    int         pulse;
    result_t    res;
    k = raw;
    if (k >= KEY_UPPER_A && k <= KEY_UPPER_Z) k = k + CASE_OFFSET;
    l = left_v;
    r = right_v;
    if (k == KEY_C) begin
      mode_now = MODE_AUTO;
    end else if (k == KEY_M) begin
      mode_now = MODE_MANUAL;
    end else if (k == KEY_O) begin
      mode_now  = MODE_STANDBY;
      l         = 0;
      r         = 0;
      angle_deg = 0;
    end else if (mode_now == MODE_MANUAL) begin
      // q and l fall through to default: no effect
      case (k)
        KEY_W: begin
          if (l < SPEED_BOUND && r < SPEED_BOUND) begin
            l = l + SPEED_STEP;
            r = r + SPEED_STEP;
          end
        end
        KEY_S: begin
          if (l > SPEED_FLOOR && r > SPEED_FLOOR) begin
            l = l - SPEED_STEP;
            r = r - SPEED_STEP;
          end
        end
        KEY_A: begin
          if (l > SPEED_FLOOR) l = l - SPEED_STEP;
          if (r < SPEED_BOUND) r = r + SPEED_STEP;
        end
        KEY_D: begin
          if (r > SPEED_FLOOR) r = r - SPEED_STEP;
          if (l < SPEED_BOUND) l = l + SPEED_STEP;
        end
        KEY_B: begin
          held_left  = l;
          held_right = r;
          l          = 0;
          r          = 0;
          paused_now = 1'b1;
        end
        KEY_N: begin
          if (paused_now) begin
            l          = held_left;
            r          = held_right;
            paused_now = 1'b0;
          end
        end
        KEY_SPACE: begin
          l = (l + r) / 2;  // truncates toward zero
          r = l;
        end
        KEY_J: if (angle_deg < ANGLE_UPPER_GATE) angle_deg = angle_deg + ANGLE_STEP;
        KEY_U: if (angle_deg > ANGLE_LOWER_GATE) angle_deg = angle_deg - ANGLE_STEP;
        KEY_P: begin
          l         = 0;
          r         = 0;
          angle_deg = 0;
        end
        default: ;
      endcase
    end
    left_v  = l;
    right_v = r;
    a = angle_deg;
    if (a > 180) a = a - 180;
    pulse = 50 + (1800 - 10 * a) / 9;
    res.left_speed     = l[7:0];
    res.right_speed    = r[7:0];
    res.right_fwd_duty = fwd_duty_of(r);
    res.right_rev_duty = rev_duty_of(r);
    res.left_fwd_duty  = fwd_duty_of(l);
    res.left_rev_duty  = rev_duty_of(l);
    res.servo_pulse    = pulse[7:0];
    res.steer_angle    = a[7:0];
    res.mode           = mode_now;
    res.paused         = paused_now;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    key_result_t ent;
    result_t     got;
    if (rst) begin
      pending_results.delete();
      left_v     = 0;
      right_v    = 0;
      held_left  = 0;
      held_right = 0;
      angle_deg  = 0;
      paused_now = 1'b0;
      mode_now   = MODE_STANDBY;
      pending    = 0;
    end else begin
      if (result_valid && result_ready) begin
        got.left_speed     = left_speed;
        got.right_speed    = right_speed;
        got.right_fwd_duty = right_fwd_duty;
        got.right_rev_duty = right_rev_duty;
        got.left_fwd_duty  = left_fwd_duty;
        got.left_rev_duty  = left_rev_duty;
        got.servo_pulse    = servo_pulse;
        got.steer_angle    = steer_angle_out;
        got.mode           = mode_t'(mode_out);
        got.paused         = paused_out;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result transaction L=%0d R=%0d", $realtime,
                     got.left_speed, got.right_speed);
        end else begin
          ent = pending_results.pop_front();
          if (got !== ent.res) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: key %02h mismatch", $realtime, ent.key);
              $display("  exp L=%0d R=%0d rf=%0d rr=%0d lf=%0d lr=%0d pulse=%0d ang=%0d mode=%0d paused=%0b",
                       ent.res.left_speed, ent.res.right_speed, ent.res.right_fwd_duty,
                       ent.res.right_rev_duty, ent.res.left_fwd_duty, ent.res.left_rev_duty,
                       ent.res.servo_pulse, ent.res.steer_angle, ent.res.mode,
                       ent.res.paused);
              $display("  got L=%0d R=%0d rf=%0d rr=%0d lf=%0d lr=%0d pulse=%0d ang=%0d mode=%0d paused=%0b",
                       got.left_speed, got.right_speed, got.right_fwd_duty,
                       got.right_rev_duty, got.left_fwd_duty, got.left_rev_duty,
                       got.servo_pulse, got.steer_angle, got.mode, got.paused);
            end
          end
        end
      end
      if (key_valid && key_ready) begin
        ent.key = key_code;
        ent.res = apply_key(key_code);
        pending_results.push_back(ent);
      end
      pending = pending_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import kcdd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned CMD_TARGET   = 1950;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [7:0] KEY_Q = 8'h71;
  localparam logic [7:0] KEY_L = 8'h6C;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic [7:0]        key_code     = 8'h00;
  logic              key_valid    = 1'b0;
  logic              result_ready = 1'b0;
  logic              key_ready;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;
  logic [5:0]        right_fwd_duty;
  logic [5:0]        right_rev_duty;
  logic [5:0]        left_fwd_duty;
  logic [5:0]        left_rev_duty;
  logic [7:0]        servo_pulse;
  logic [7:0]        steer_angle_out;
  logic [1:0]        mode_out;
  logic              paused_out;
  logic              result_valid;
  int unsigned       fail_count;
  int unsigned       pending;

  int unsigned cmd_count  = 0;
  int unsigned burst_left = 0;

  key_command_differential_drive_core DUT (.*);

  drive_state_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_command(input logic [7:0] raw);
    logic [7:0] k;
    k = raw;
    if (k >= KEY_UPPER_A && k <= KEY_UPPER_Z) k = k + CASE_OFFSET;
    case (k)
      KEY_W, KEY_S, KEY_A, KEY_D, KEY_B, KEY_N, KEY_SPACE, KEY_J, KEY_U, KEY_P,
      KEY_C, KEY_M, KEY_O: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // random upper-casing of letters
  function automatic logic [7:0] shout(input logic [7:0] k);
    if (k >= KEY_UPPER_A + CASE_OFFSET && k <= KEY_UPPER_Z + CASE_OFFSET &&
        $urandom_range(0, 3) == 0)
      return k - CASE_OFFSET;
    return k;
  endfunction

  function automatic logic [7:0] command_key(input int unsigned idx);
    case (idx)
      0: return KEY_W;
      1: return KEY_S;
      2: return KEY_A;
      3: return KEY_D;
      4: return KEY_B;
      5: return KEY_N;
      6: return KEY_SPACE;
      7: return KEY_J;
      8: return KEY_U;
      default: return KEY_P;
    endcase
  endfunction

  function automatic logic [7:0] pick_key();
    int unsigned r;
    logic [7:0]  k;
    r = $urandom_range(0, 99);
    if (r < 70)      k = command_key($urandom_range(0, 9));
    else if (r < 78) k = KEY_M;
    else if (r < 81) k = KEY_C;
    else if (r < 84) k = KEY_O;
    else if (r < 88) k = r[0] ? KEY_Q : KEY_L;
    else             k = 8'($urandom_range(0, 255));
    return shout(k);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_key(input logic [7:0] k);
    key_code  <= k;
    key_valid <= 1'b1;
    do @(posedge clk); while (!key_ready);
    if (is_command(k)) cmd_count++;
    @(negedge clk);
    if (burst_left == 0) begin
      key_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_str(input string s, input bit mixed);
    for (int i = 0; i < s.len(); i++) send_key(mixed ? shout(s[i]) : s[i]);
  endtask

  // Runs both speeds to the bound, then uses blocked steps and averaging
  // to land on 99, so one more step reaches the +/-104 extreme and the last is blocked.
  task automatic climb(input bit upward);
    send_str("mp", 1'b1);
    repeat ($urandom_range(20, 24)) send_key(shout(upward ? KEY_W : KEY_S));
    send_str(upward ? "d wd ww" : "a sa ss", 1'b1);
  endtask

  initial begin : rx_side
    int unsigned style;
    int unsigned tick;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      repeat ($urandom_range(16, 160)) begin
        @(negedge clk);
        tick++;
        // long hold-off: block fills and back-pressures the key channel
        if (tick == 1200 || tick == 6000) begin
          result_ready <= 1'b0;
          repeat (400) begin
            @(negedge clk);
            tick++;
          end
        end
        case (style)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          2:       result_ready <= (tick % 3) != 2;
          default: result_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: byte extremes, ignored keys outside manual, every command
    send_key(8'h00);
    send_key(8'hFF);
    send_str("wcjmWsadADbnn jJupqlzx", 1'b0);
    send_key(8'h80);
    send_str("oM", 1'b0);

    while (cmd_count < CMD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 10)) send_key(pick_key());
      end else if (pick < 42) begin
        climb(1'b1);
      end else if (pick < 54) begin
        climb(1'b0);
      end else if (pick < 64) begin
        send_key(shout(KEY_M));
        repeat ($urandom_range(0, 6)) send_key(pick_key());
        send_key(shout(KEY_B));
        repeat ($urandom_range(0, 4)) send_key(pick_key());
        send_key(shout(KEY_N));
      end else if (pick < 72) begin
        send_key(shout(KEY_M));
        repeat ($urandom_range(30, 40)) send_key(shout(KEY_J));
        repeat ($urandom_range(30, 40)) send_key(shout(KEY_U));
      end else if (pick < 88) begin
        send_key(shout(KEY_M));
        repeat ($urandom_range(2, 25)) send_key(shout(command_key($urandom_range(0, 9))));
      end else begin
        repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(0, 255)));
      end
    end
    key_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
